>>> rtl/ppn2d_pkg.sv
// Shared types and constants of the periodic 2D gradient-noise block.
`default_nettype none

package ppn2d_pkg;

  // Configuration register indexes.
  typedef enum logic {
    CFG_MASK_X = 1'b0,
    CFG_MASK_Y = 1'b1
  } cfg_reg_e;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned NoiseWidth = 16;
  localparam int unsigned CellBits   = 8;

  // Output scale, 0.507 in Q16.
  localparam logic signed [17:0] NoiseScale = 18'sd33227;

  localparam logic signed [NoiseWidth-1:0] NoiseMax = 16'sh7fff;
  localparam logic signed [NoiseWidth-1:0] NoiseMin = 16'sh8000;

  // Standard permutation table of the improved gradient noise.
  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

`default_nettype wire

>>> rtl/ppn2d_fade.sv
// Five-stage pipelined quintic fade curve 6t^5 - 15t^4 + 10t^3 in Horner form.
`default_nettype none

module ppn2d_fade #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [FracBits-1:0]   frac_i,
  output logic signed [FracBits+4:0] fade_o
);

  localparam int unsigned Width = FracBits + 5;
  localparam int unsigned ProdW = Width + FracBits + 1;

  localparam logic signed [Width-1:0] Fifteen = Width'(15) << FracBits;
  localparam logic signed [Width-1:0] Ten     = Width'(10) << FracBits;

  // The fraction travels beside each partial result.
  logic [FracBits-1:0]     frac_q [4];
  logic signed [Width-1:0] a_q, b_q, c_q, d_q, fade_q;
  logic signed [Width-1:0] frac_ext, a_d;
  logic signed [ProdW-1:0] prod_b, prod_c, prod_d, prod_f;

  assign frac_ext = $signed({5'b0, frac_i});
  assign a_d      = (frac_ext <<< 2) + (frac_ext <<< 1) - Fifteen;

  assign prod_b = $signed({1'b0, frac_q[0]}) * a_q;
  assign prod_c = $signed({1'b0, frac_q[1]}) * b_q;
  assign prod_d = $signed({1'b0, frac_q[2]}) * c_q;
  assign prod_f = $signed({1'b0, frac_q[3]}) * d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac_q[0] <= frac_i;
      frac_q[1] <= frac_q[0];
      frac_q[2] <= frac_q[1];
      frac_q[3] <= frac_q[2];
      a_q       <= a_d;
      b_q       <= Width'(prod_b >>> FracBits) + Ten;
      c_q       <= Width'(prod_c >>> FracBits);
      d_q       <= Width'(prod_d >>> FracBits);
      fade_q    <= Width'(prod_f >>> FracBits);
    end
  end

  assign fade_o = fade_q;

endmodule

`default_nettype wire

>>> rtl/periodic_perlin_noise_2d.sv
// Top level of the periodic 2D gradient-noise generator, eight-stage pipeline.
//
// Usage: each item on the slave stream carries one point (x, y) in signed fixed
// point with FracBits fraction bits, x in tdata[31:0] and y in tdata[63:32].
// Each item on the master stream carries one noise sample in signed Q1.15,
// saturated, in tdata[15:0]. Every input item yields exactly one output item,
// in order.
// The configuration port holds two period masks that are ANDed with the x and
// y cell indexes, so the noise tiles with a period of mask + 1 cells when the
// mask is one less than a power of two; 255 gives the full period of 256 cells.
// Masks should be written only while the pipeline is empty.
// One item is taken every cycle while the receiver does not stall. The depth
// comes from the fade curve, four chained multiplications, followed by two
// lerp stages and the output scaling.
// When the receiver stalls, the whole pipeline holds; a new item is still taken
// whenever the output register is empty or being drained in the same cycle.
// Reset clears the valid bits and sets both masks to 255; the permutation
// table is a constant and needs no reset.
`default_nettype none

module periodic_perlin_noise_2d #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration write port.
  input  wire logic                      cfg_we_i,
  input  wire ppn2d_pkg::cfg_reg_e       cfg_idx_i,
  input  wire logic [7:0]                cfg_data_i,
  // Slave stream.
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [63:0]               s_axis_tdata,  // x_coord, y_coord
  // Master stream.
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [15:0]                    m_axis_tdata   // noise_value
);

  import ppn2d_pkg::*;

  localparam int unsigned Depth  = 8;
  localparam int unsigned FadeW  = FracBits + 5;
  localparam int unsigned DeltaW = FracBits + 1;
  localparam int unsigned GradW  = FracBits + 3;
  localparam int unsigned DiffW  = FracBits + 4;
  localparam int unsigned LerpW  = FracBits + 4;
  localparam int unsigned RW     = FracBits + 5;
  localparam int unsigned LProdW = FadeW + DiffW;
  localparam int unsigned RProdW = FadeW + LerpW + 1;
  localparam int unsigned SProdW = RW + 18;
  localparam int unsigned QW     = SProdW - FracBits - 1;

  localparam logic signed [SProdW-1:0] Half = SProdW'(1) << FracBits;
  localparam logic signed [QW-1:0]     QMax = QW'(NoiseMax);
  localparam logic signed [QW-1:0]     QMin = QW'(NoiseMin);

  // Gradient of one corner: +-u +-2v with u, v picked by the hash.
  function automatic logic signed [GradW-1:0] grad(
    input logic [2:0]               h,
    input logic signed [DeltaW-1:0] dx,
    input logic signed [DeltaW-1:0] dy
  );
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
    logic signed [GradW-1:0] gu;
    logic signed [GradW-1:0] gv;
    u  = h[2] ? GradW'(dy) : GradW'(dx);
    v  = h[2] ? GradW'(dx) : GradW'(dy);
    gu = h[0] ? -u : u;
    gv = h[1] ? -(v <<< 1) : (v <<< 1);
    return gu + gv;
  endfunction

  // Configuration registers.
  logic [7:0] mask_x_q, mask_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_x_q <= 8'hff;
      mask_y_q <= 8'hff;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASK_X: mask_x_q <= cfg_data_i;
        CFG_MASK_Y: mask_y_q <= cfg_data_i;
      endcase
    end
  end

  // Global pipeline enable: everything moves unless the output is held.
  logic             en;
  logic [Depth-1:0] vld_q;

  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // Input split: the low cell bits and the fraction of each coordinate.
  logic [CoordWidth-1:0] x_in, y_in;
  logic [CellBits-1:0]   cell_x, cell_y;

  assign x_in   = s_axis_tdata[CoordWidth-1:0];
  assign y_in   = s_axis_tdata[2*CoordWidth-1:CoordWidth];
  assign cell_x = x_in[FracBits+CellBits-1:FracBits];
  assign cell_y = y_in[FracBits+CellBits-1:FracBits];

  // Stage 0: masked corner indexes and the first level of the hash.
  logic [FracBits-1:0] fx0_q, fy0_q;
  logic [7:0]          ix0_q, ix1_q, p0_q, p1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx0_q <= x_in[FracBits-1:0];
      fy0_q <= y_in[FracBits-1:0];
      ix0_q <= cell_x & mask_x_q;
      ix1_q <= 8'(cell_x + 8'd1) & mask_x_q;
      p0_q  <= PERM_ROM[cell_y & mask_y_q];
      p1_q  <= PERM_ROM[8'(cell_y + 8'd1) & mask_y_q];
    end
  end

  // Stage 1: corner hashes, only the low three bits matter.
  logic [FracBits-1:0] fx1_q, fy1_q;
  logic [2:0]          h00_q, h01_q, h10_q, h11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx1_q <= fx0_q;
      fy1_q <= fy0_q;
      h00_q <= PERM_ROM[8'(ix0_q + p0_q)][2:0];
      h01_q <= PERM_ROM[8'(ix0_q + p1_q)][2:0];
      h10_q <= PERM_ROM[8'(ix1_q + p0_q)][2:0];
      h11_q <= PERM_ROM[8'(ix1_q + p1_q)][2:0];
    end
  end

  // Stage 2: corner gradients. The far-corner offset f - 1 is the fraction
  // with a sign bit of one in front.
  logic signed [DeltaW-1:0] dx0, dx1, dy0, dy1;
  logic signed [GradW-1:0]  g00_q, g01_q, g10_q, g11_q;

  assign dx0 = $signed({1'b0, fx1_q});
  assign dx1 = $signed({1'b1, fx1_q});
  assign dy0 = $signed({1'b0, fy1_q});
  assign dy1 = $signed({1'b1, fy1_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      g00_q <= grad(h00_q, dx0, dy0);
      g01_q <= grad(h01_q, dx0, dy1);
      g10_q <= grad(h10_q, dx1, dy0);
      g11_q <= grad(h11_q, dx1, dy1);
    end
  end

  // Stage 3: differences along y for the two x columns.
  logic signed [GradW-1:0] g00_3_q, g10_3_q;
  logic signed [DiffW-1:0] dif0_3_q, dif1_3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g00_3_q  <= g00_q;
      g10_3_q  <= g10_q;
      dif0_3_q <= DiffW'(g01_q) - DiffW'(g00_q);
      dif1_3_q <= DiffW'(g11_q) - DiffW'(g10_q);
    end
  end

  // Stage 4: waits for the fade curves, which land in this stage.
  logic signed [GradW-1:0] g00_4_q, g10_4_q;
  logic signed [DiffW-1:0] dif0_4_q, dif1_4_q;
  logic signed [FadeW-1:0] fade_s, fade_t;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g00_4_q  <= g00_3_q;
      g10_4_q  <= g10_3_q;
      dif0_4_q <= dif0_3_q;
      dif1_4_q <= dif1_3_q;
    end
  end

  ppn2d_fade #(
    .FracBits(FracBits)
  ) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (x_in[FracBits-1:0]),
    .fade_o (fade_s)
  );

  ppn2d_fade #(
    .FracBits(FracBits)
  ) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (y_in[FracBits-1:0]),
    .fade_o (fade_t)
  );

  // Stage 5: lerp along y in both columns.
  logic signed [LProdW-1:0] lp0, lp1;
  logic signed [LerpW-1:0]  n0_q, n1_q;
  logic signed [FadeW-1:0]  s5_q;

  assign lp0 = fade_t * dif0_4_q;
  assign lp1 = fade_t * dif1_4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q <= fade_s;
      n0_q <= LerpW'(lp0 >>> FracBits) + LerpW'(g00_4_q);
      n1_q <= LerpW'(lp1 >>> FracBits) + LerpW'(g10_4_q);
    end
  end

  // Stage 6: lerp along x.
  logic signed [LerpW:0]    ndif;
  logic signed [RProdW-1:0] rp;
  logic signed [RW-1:0]     r_q;

  assign ndif = (LerpW+1)'(n1_q) - (LerpW+1)'(n0_q);
  assign rp   = s5_q * ndif;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= RW'(rp >>> FracBits) + RW'(n0_q);
    end
  end

  // Stage 7: scale by 0.507, round and saturate to Q1.15.
  logic signed [SProdW-1:0]     sp;
  logic signed [QW-1:0]         q;
  logic signed [NoiseWidth-1:0] out_d, out_q;

  assign sp = r_q * NoiseScale + Half;
  assign q  = QW'(sp >>> (FracBits + 1));

  always_comb begin
    priority if (q > QMax) begin
      out_d = NoiseMax;
    end else if (q < QMin) begin
      out_d = NoiseMin;
    end else begin
      out_d = NoiseWidth'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule

`default_nettype wire

>>> rtl/ppn2d_checker.sv
// Port-level checks of the gradient-noise pipeline and their binding.
`default_nettype none

module ppn2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [63:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A held output item keeps its value and stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output item changed while stalled");

  // The pipeline refuses input only while its output item is being held.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input refused without an output stall");

  // An output item shows up only if an item was taken before it:
  // right after reset the pipeline is empty.
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

  // With no stall, an item taken now has its result shown once it has passed every stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after eight cycles");

endmodule

bind periodic_perlin_noise_2d ppn2d_checker u_ppn2d_checker (.*);

`default_nettype wire
